// ===== rtl/core/dxt_pkg.sv =====
// ----------------------------------------------------------------------------
// dxt_pkg
// Types, codes and small arithmetic helpers shared by the block decoder.
// ----------------------------------------------------------------------------
package dxt_pkg;

	// Format codes held in the format register. The unused code decodes as DXT1.
	localparam logic [1:0] MODE_DXT1 = 2'd0;
	localparam logic [1:0] MODE_DXT3 = 2'd1;
	localparam logic [1:0] MODE_DXT5 = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_FORMAT = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;

	localparam int CFG_DATA_W = 11;

	// Reciprocals for the constant divisions; each is exact over the range it sees.
	localparam logic [9:0]  RECIP3       = 10'd683;
	localparam int          RECIP3_SHIFT = 11;
	localparam logic [11:0] RECIP5       = 12'd3277;
	localparam logic [11:0] RECIP7       = 12'd2341;
	localparam int          RECIP_SHIFT  = 14;

	// Depth of the descriptor queue between the front and the back.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [63:0] color_block;
		logic [63:0] alpha_block;
		logic [7:0]  block_col;
		logic [7:0]  block_row;
	} blk_t;

	typedef struct packed {
		logic [9:0] pixel_x;
		logic [9:0] pixel_y;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
		logic       last;
	} pix_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} bgr_t;

	// One classified block as the back part needs it.
	typedef struct packed {
		bgr_t [3:0]  pal;
		logic        three;
		logic [31:0] cidx;
		logic [63:0] ablk;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [1:0]  last_col;
		logic [1:0]  last_row;
	} desc_t;

	// Truncating v*255/31: 8v plus the number of thresholds ceil(31m/7) reached.
	function automatic logic [7:0] expand5(input logic [4:0] v);
		logic [7:0] e;
		e = {v, 3'b000};
		e = e + 8'(v >= 5'd5) + 8'(v >= 5'd9) + 8'(v >= 5'd14) + 8'(v >= 5'd18)
			+ 8'(v >= 5'd23) + 8'(v >= 5'd27) + 8'(v >= 5'd31);
		return e;
	endfunction

	// Truncating v*255/63: 4v plus floor(v/21).
	function automatic logic [7:0] expand6(input logic [5:0] v);
		logic [7:0] e;
		e = {v, 2'b00};
		e = e + 8'(v >= 6'd21) + 8'(v >= 6'd42) + 8'(v >= 6'd63);
		return e;
	endfunction

	// Division by three for values up to 765.
	function automatic logic [7:0] div3(input logic [9:0] v);
		logic [19:0] p;
		p = 20'(v) * 20'(RECIP3);
		return p[RECIP3_SHIFT +: 8];
	endfunction

endpackage

// ===== rtl/core/dxt_block_texture_decoder.sv =====
// ----------------------------------------------------------------------------
// dxt_block_texture_decoder
// DXT1/DXT3/DXT5 4x4 block decoder with clipping to the image size.
// ----------------------------------------------------------------------------
// Each pushed block yields one BGRA pixel per covered image pixel, in raster
// order within the block, with last set on the final one. The pixel emitter
// produces one pixel per cycle unless the receiver stalls; a block wholly
// outside the image is dropped in the front and yields nothing. The front
// builds the palette in two pipeline stages and hands it over through a
// two-entry queue, so blocks are taken while earlier ones are still being
// emitted; the input stops only when the queue is full and a covered block
// waits in stage two. A block passes both stages, the queue, the descriptor
// and b1 registers before its first pixel reaches the output. Configuration
// must be written by the user only while idle; the decoder does not check it.
module dxt_block_texture_decoder import dxt_pkg::*; #(
	parameter int MAX_IMAGE_DIM = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  blk_t                  blk,
	output logic                  empty,
	input  logic                  pop,
	output pix_t                  pix,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [1:0]            mode_q;
	logic [CFG_DATA_W-1:0] width_q, height_q;

	logic  q_wr, q_rd, q_full, q_empty;
	desc_t q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_DXT1;
			width_q  <= CFG_DATA_W'(1024);
			height_q <= CFG_DATA_W'(1024);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FORMAT: mode_q   <= cfg_data[1:0];
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	dxt_front #(
		.MAX_IMAGE_DIM(MAX_IMAGE_DIM)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.blk    (blk),
		.width  (width_q),
		.height (height_q),
		.q_full (q_full),
		.q_wr   (q_wr),
		.q_data (q_wdata)
	);

	dxt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wdata),
		.q_full  (q_full),
		.rd      (q_rd),
		.rd_data (q_rdata),
		.q_empty (q_empty)
	);

	dxt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.mode    (mode_q),
		.rd_data (q_rdata),
		.q_empty (q_empty),
		.rd      (q_rd),
		.empty   (empty),
		.pop     (pop),
		.pix     (pix)
	);

endmodule

// ===== rtl/core/dxt_front.sv =====
// ----------------------------------------------------------------------------
// dxt_front
// Accepts compressed blocks, builds the colour palette, works out the covered
// part of the block and drops blocks that lie wholly outside the image.
// ----------------------------------------------------------------------------
module dxt_front import dxt_pkg::*; #(
	parameter int MAX_IMAGE_DIM = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  blk_t                  blk,
	input  logic [CFG_DATA_W-1:0] width,
	input  logic [CFG_DATA_W-1:0] height,
	input  logic                  q_full,
	output logic                  q_wr,
	output desc_t                 q_data
);

	localparam int DIM_BITS = $clog2(MAX_IMAGE_DIM + 1);
	localparam int LIM_W = (DIM_BITS > CFG_DATA_W) ? DIM_BITS : CFG_DATA_W;
	localparam logic [LIM_W-1:0] DIM_LIM = LIM_W'(MAX_IMAGE_DIM);

	logic       v_s1, v_s2;
	blk_t       blk_s1;
	logic       advance;

	logic [LIM_W-1:0] wlim, hlim, ox, oy, wdiff, hdiff;
	logic             cov;
	logic [1:0]       lc, lr;
	logic [15:0]      c0, c1;
	logic [2:0][7:0]  e0, e1;
	logic [2:0][9:0]  twoa, twob;
	logic [2:0][8:0]  pair;

	logic [2:0][7:0]  e0_s2, e1_s2;
	logic [2:0][9:0]  twoa_s2, twob_s2;
	logic [2:0][8:0]  pair_s2;
	logic             three_s2, cov_s2;
	logic [1:0]       lc_s2, lr_s2;
	logic [31:0]      cidx_s2;
	logic [63:0]      ablk_s2;
	logic [7:0]       col_s2, row_s2;

	// The whole front stalls only when a covered block waits on a full queue.
	assign advance = !(v_s2 && cov_s2 && q_full);
	assign full    = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s1 <= push;
			v_s2 <= v_s1;
		end
	end

	always_comb begin
		wlim = (LIM_W'(width) < DIM_LIM) ? LIM_W'(width) : DIM_LIM;
		hlim = (LIM_W'(height) < DIM_LIM) ? LIM_W'(height) : DIM_LIM;
		ox = LIM_W'({blk_s1.block_col, 2'b00});
		oy = LIM_W'({blk_s1.block_row, 2'b00});
		wdiff = wlim - ox;
		hdiff = hlim - oy;
		cov = (wlim > ox) && (hlim > oy);
		lc = (wdiff >= LIM_W'(4)) ? 2'd3 : 2'(wdiff - LIM_W'(1));
		lr = (hdiff >= LIM_W'(4)) ? 2'd3 : 2'(hdiff - LIM_W'(1));

		c0 = blk_s1.color_block[15:0];
		c1 = blk_s1.color_block[31:16];
		e0[0] = expand5(c0[4:0]);
		e0[1] = expand6(c0[10:5]);
		e0[2] = expand5(c0[15:11]);
		e1[0] = expand5(c1[4:0]);
		e1[1] = expand6(c1[10:5]);
		e1[2] = expand5(c1[15:11]);
		for (int ch = 0; ch < 3; ch++) begin
			twoa[ch] = 10'({e0[ch], 1'b0}) + 10'(e1[ch]);
			twob[ch] = 10'(e0[ch]) + 10'({e1[ch], 1'b0});
			pair[ch] = 9'(e0[ch]) + 9'(e1[ch]);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (push) begin
				blk_s1 <= blk;
			end
			e0_s2    <= e0;
			e1_s2    <= e1;
			twoa_s2  <= twoa;
			twob_s2  <= twob;
			pair_s2  <= pair;
			three_s2 <= (c0 <= c1);
			cov_s2   <= cov;
			lc_s2    <= lc;
			lr_s2    <= lr;
			cidx_s2  <= blk_s1.color_block[63:32];
			ablk_s2  <= blk_s1.alpha_block;
			col_s2   <= blk_s1.block_col;
			row_s2   <= blk_s1.block_row;
		end
	end

	// Palette entries two and three follow the three-colour rule in every format.
	always_comb begin
		q_data.pal[0] = '{blue: e0_s2[0], green: e0_s2[1], red: e0_s2[2]};
		q_data.pal[1] = '{blue: e1_s2[0], green: e1_s2[1], red: e1_s2[2]};
		if (three_s2) begin
			q_data.pal[2] = '{blue: pair_s2[0][8:1], green: pair_s2[1][8:1],
				red: pair_s2[2][8:1]};
			q_data.pal[3] = '{blue: 8'd0, green: 8'd0, red: 8'd0};
		end else begin
			q_data.pal[2] = '{blue: div3(twoa_s2[0]), green: div3(twoa_s2[1]),
				red: div3(twoa_s2[2])};
			q_data.pal[3] = '{blue: div3(twob_s2[0]), green: div3(twob_s2[1]),
				red: div3(twob_s2[2])};
		end
		q_data.three    = three_s2;
		q_data.cidx     = cidx_s2;
		q_data.ablk     = ablk_s2;
		q_data.col      = col_s2;
		q_data.row      = row_s2;
		q_data.last_col = lc_s2;
		q_data.last_row = lr_s2;
	end

	assign q_wr = v_s2 && cov_s2 && !q_full;

endmodule

// ===== rtl/core/dxt_queue.sv =====
// ----------------------------------------------------------------------------
// dxt_queue
// Short descriptor queue that decouples the front from the pixel emitter.
// ----------------------------------------------------------------------------
module dxt_queue import dxt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  desc_t wr_data,
	output logic  q_full,
	input  logic  rd,
	output desc_t rd_data,
	output logic  q_empty
);

	desc_t             mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign q_full  = (cnt_q == QCNT_W'(QDEPTH));
	assign q_empty = (cnt_q == '0);
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(wr) - QCNT_W'(rd);
		end
	end

endmodule

// ===== rtl/core/dxt_back.sv =====
// ----------------------------------------------------------------------------
// dxt_back
// Walks the covered pixels of each queued block, one per cycle unless the
// output stalls, and decodes colour and alpha into the result register.
// ----------------------------------------------------------------------------
module dxt_back import dxt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] mode,
	input  desc_t      rd_data,
	input  logic       q_empty,
	output logic       rd,
	output logic       empty,
	input  logic       pop,
	output pix_t       pix
);

	typedef enum logic [1:0] {
		ASEL_PASS,
		ASEL_DIV5,
		ASEL_DIV7
	} asel_t;

	desc_t      cur_q;
	logic       act_q;
	logic [1:0] px_q, py_q;
	logic       adv, at_end;

	logic [15:0][1:0] cidx_w;
	logic [15:0][3:0] nib_w;
	logic [15:0][2:0] aidx_w;
	logic [3:0]       k;
	logic [1:0]       ci;
	logic [7:0]       a0, a1;
	logic [2:0]       ai, w0, w1;

	asel_t       asel;
	logic [7:0]  apass;
	logic [10:0] asum;

	logic        v_b1;
	logic [9:0]  x_b1, y_b1;
	bgr_t        bgr_b1;
	asel_t       asel_b1;
	logic [7:0]  apass_b1;
	logic [10:0] asum_b1;
	logic        last_b1;

	logic        v_out_q;
	logic [21:0] prod5, prod7;
	logic [7:0]  afin;

	assign adv    = !v_out_q || pop;
	assign empty  = !v_out_q;
	assign at_end = (px_q == cur_q.last_col) && (py_q == cur_q.last_row);
	assign rd     = !q_empty && (!act_q || (adv && at_end));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= 1'b0;
			px_q    <= 2'd0;
			py_q    <= 2'd0;
			v_b1    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (rd) begin
				act_q <= 1'b1;
				px_q  <= 2'd0;
				py_q  <= 2'd0;
			end else if (act_q && adv) begin
				if (at_end) begin
					act_q <= 1'b0;
				end else if (px_q == cur_q.last_col) begin
					px_q <= 2'd0;
					py_q <= py_q + 2'd1;
				end else begin
					px_q <= px_q + 2'd1;
				end
			end
			if (adv) begin
				v_b1    <= act_q;
				v_out_q <= v_b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd) begin
			cur_q <= rd_data;
		end
	end

	always_comb begin
		cidx_w = cur_q.cidx;
		nib_w  = cur_q.ablk;
		aidx_w = cur_q.ablk[63:16];
		k  = {py_q, px_q};
		ci = cidx_w[k];
		a0 = cur_q.ablk[7:0];
		a1 = cur_q.ablk[15:8];
		ai = aidx_w[k];
		// Both weightings share the a1 weight; only the a0 weight differs.
		w1 = ai - 3'd1;
		w0 = (a0 > a1) ? 3'(4'd8 - {1'b0, ai}) : 3'(4'd6 - {1'b0, ai});
		asum  = 11'(w0) * 11'(a0) + 11'(w1) * 11'(a1);
		asel  = ASEL_PASS;
		apass = 8'd255;
		case (mode)
			MODE_DXT3: begin
				apass = {nib_w[k], nib_w[k]};
			end
			MODE_DXT5: begin
				if (ai == 3'd0) begin
					apass = a0;
				end else if (ai == 3'd1) begin
					apass = a1;
				end else if (a0 > a1) begin
					asel = ASEL_DIV7;
				end else if (ai == 3'd6) begin
					apass = 8'd0;
				end else if (ai == 3'd7) begin
					apass = 8'd255;
				end else begin
					asel = ASEL_DIV5;
				end
			end
			default: begin
				apass = (cur_q.three && ci == 2'd3) ? 8'd0 : 8'd255;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_b1     <= {cur_q.col, px_q};
			y_b1     <= {cur_q.row, py_q};
			bgr_b1   <= cur_q.pal[ci];
			asel_b1  <= asel;
			apass_b1 <= apass;
			asum_b1  <= asum;
			last_b1  <= at_end;
		end
	end

	always_comb begin
		prod5 = 22'(asum_b1) * 22'(RECIP5);
		prod7 = 22'(asum_b1) * 22'(RECIP7);
		case (asel_b1)
			ASEL_DIV5: afin = prod5[RECIP_SHIFT +: 8];
			ASEL_DIV7: afin = prod7[RECIP_SHIFT +: 8];
			default:   afin = apass_b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix.pixel_x <= x_b1;
			pix.pixel_y <= y_b1;
			pix.blue    <= bgr_b1.blue;
			pix.green   <= bgr_b1.green;
			pix.red     <= bgr_b1.red;
			pix.alpha   <= afin;
			pix.last    <= last_b1;
		end
	end

endmodule

// ===== sim/tb_dxt_block_texture_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dxt_block_texture_decoder
// Self-checking bench for the DXT block decoder: blocks go in through the push
// queue, and every decoded pixel is checked against a predicted pixel stream.
// Directed tests cover palettes, alpha modes and clipping. A random stream
// then runs under several format and image size settings with random stalls.
// ----------------------------------------------------------------------------
module tb_dxt_block_texture_decoder;
	import dxt_pkg::*;

	localparam int          MAX_DIM      = 1024;
	localparam int          DRAIN_CYCLES = 24;
	localparam int          CYCLE_LIMIT  = 300000;
	localparam logic [1:0]  MODE_UNUSED  = 2'd3;
	localparam int          ITEMS_PER_PHASE = 33;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  push      = 1'b0;
	logic                  full;
	blk_t                  blk       = '0;
	logic                  empty;
	logic                  pop       = 1'b0;
	pix_t                  pix;
	logic                  cfg_we    = 1'b0;
	logic [1:0]            cfg_index = CFG_FORMAT;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Shadow copy of the configuration registers.
	logic [1:0]            cur_mode = MODE_DXT1;
	logic [CFG_DATA_W-1:0] img_w    = 11'd1024;
	logic [CFG_DATA_W-1:0] img_h    = 11'd1024;

	pix_t expected_pixels[$];
	int   mismatches  = 0;
	int   cycle_count = 0;
	bit   steady      = 1'b0;

	dxt_block_texture_decoder #(
		.MAX_IMAGE_DIM(MAX_DIM)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.blk      (blk),
		.empty    (empty),
		.pop      (pop),
		.pix      (pix),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// The receiver stalls now and then unless a steady stretch is running.
	always @(negedge clk) begin
		pop <= steady || ($urandom_range(99) >= 8);
	end

	// Works out the pixels one block decodes to under the current settings.
	task automatic predict_pixels(input blk_t b);
		pix_t        px[16];
		int          n, k, x, y, ci, ai, a, a0, a1, wlim, hlim;
		int          red[4], grn[4], blu[4];
		logic [15:0] c0, c1;
		logic        three;
		c0 = b.color_block[15:0];
		c1 = b.color_block[31:16];
		three = (c0 <= c1);
		wlim = (img_w < MAX_DIM) ? int'(img_w) : MAX_DIM;
		hlim = (img_h < MAX_DIM) ? int'(img_h) : MAX_DIM;
		red[0] = int'(c0[15:11]) * 255 / 31;
		grn[0] = int'(c0[10:5]) * 255 / 63;
		blu[0] = int'(c0[4:0]) * 255 / 31;
		red[1] = int'(c1[15:11]) * 255 / 31;
		grn[1] = int'(c1[10:5]) * 255 / 63;
		blu[1] = int'(c1[4:0]) * 255 / 31;
		if (!three) begin
			red[2] = (2 * red[0] + red[1]) / 3;
			grn[2] = (2 * grn[0] + grn[1]) / 3;
			blu[2] = (2 * blu[0] + blu[1]) / 3;
			red[3] = (red[0] + 2 * red[1]) / 3;
			grn[3] = (grn[0] + 2 * grn[1]) / 3;
			blu[3] = (blu[0] + 2 * blu[1]) / 3;
		end else begin
			red[2] = (red[0] + red[1]) / 2;
			grn[2] = (grn[0] + grn[1]) / 2;
			blu[2] = (blu[0] + blu[1]) / 2;
			red[3] = 0;
			grn[3] = 0;
			blu[3] = 0;
		end
		a0 = int'(b.alpha_block[7:0]);
		a1 = int'(b.alpha_block[15:8]);
		n = 0;
		for (k = 0; k < 16; k++) begin
			x = 4 * int'(b.block_col) + (k % 4);
			y = 4 * int'(b.block_row) + (k / 4);
			if (x >= wlim || y >= hlim)
				continue;
			ci = int'(b.color_block[32 + 2 * k +: 2]);
			if (cur_mode == MODE_DXT3) begin
				a = int'(b.alpha_block[4 * k +: 4]) * 17;
			end else if (cur_mode == MODE_DXT5) begin
				ai = int'(b.alpha_block[16 + 3 * k +: 3]);
				if (ai == 0)
					a = a0;
				else if (ai == 1)
					a = a1;
				else if (a0 > a1)
					a = ((8 - ai) * a0 + (ai - 1) * a1) / 7;
				else if (ai == 6)
					a = 0;
				else if (ai == 7)
					a = 255;
				else
					a = ((6 - ai) * a0 + (ai - 1) * a1) / 5;
			end else begin
				a = (three && ci == 3) ? 0 : 255;
			end
			px[n]         = '0;
			px[n].pixel_x = 10'(x);
			px[n].pixel_y = 10'(y);
			px[n].blue    = 8'(blu[ci]);
			px[n].green   = 8'(grn[ci]);
			px[n].red     = 8'(red[ci]);
			px[n].alpha   = 8'(a);
			n++;
		end
		if (n > 0)
			px[n - 1].last = 1'b1;
		for (k = 0; k < n; k++)
			expected_pixels.push_back(px[k]);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		pix_t want;
		if (arst_n && !empty && pop) begin
			if (expected_pixels.size() == 0) begin
				$error("pixel transfer with nothing expected: x %0d y %0d",
					pix.pixel_x, pix.pixel_y);
				mismatches++;
			end else begin
				want = expected_pixels.pop_front();
				check_field("pixel_x", int'(want.pixel_x), int'(pix.pixel_x));
				check_field("pixel_y", int'(want.pixel_y), int'(pix.pixel_y));
				check_field("blue", int'(want.blue), int'(pix.blue));
				check_field("green", int'(want.green), int'(pix.green));
				check_field("red", int'(want.red), int'(pix.red));
				check_field("alpha", int'(want.alpha), int'(pix.alpha));
				check_field("last", int'(want.last), int'(pix.last));
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer,
	// leaving push high so back-to-back blocks need no gap.
	task automatic send_block(input blk_t b);
		bit taken;
		while (!steady && $urandom_range(99) < 8) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		blk  <= b;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !full;
		end
		predict_pixels(b);
		@(negedge clk);
	endtask

	// Blocks that are clipped away produce nothing, so the decoder may still
	// be busy after the last expected pixel; the extra cycles cover that.
	task automatic wait_drain();
		push <= 1'b0;
		while (expected_pixels.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		case (index)
			CFG_FORMAT: cur_mode = value[1:0];
			CFG_WIDTH:  img_w = value;
			CFG_HEIGHT: img_h = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic blk_t make_block(input logic [63:0] cb, input logic [63:0] ab,
		input int col, input int row);
		blk_t b;
		b.color_block = cb;
		b.alpha_block = ab;
		b.block_col   = 8'(col);
		b.block_row   = 8'(row);
		return b;
	endfunction

	function automatic blk_t random_block(input int col_hi, input int row_hi);
		blk_t b;
		b.color_block = {$urandom, $urandom};
		b.alpha_block = {$urandom, $urandom};
		if ($urandom_range(9) == 0) begin
			b.block_col = 8'($urandom);
			b.block_row = 8'($urandom);
		end else begin
			b.block_col = 8'($urandom_range(col_hi));
			b.block_row = 8'($urandom_range(row_hi));
		end
		return b;
	endfunction

	// Index word 0xE4E4E4E4 walks the pixels through palette entries 0..3.
	task automatic test_dxt1_palettes();
		send_block(make_block({32'hE4E4E4E4, 16'h0000, 16'hFFFF}, 64'h0, 0, 0));
		send_block(make_block({32'hE4E4E4E4, 16'hFFFF, 16'h0000}, 64'h0, 255, 255));
		send_block(make_block({32'hE4E4E4E4, 16'h8410, 16'h8410}, 64'h0, 255, 0));
		send_block(make_block({32'h1B1B1B1B, 16'h07E0, 16'hF81F}, {$urandom, $urandom},
			0, 255));
		send_block(make_block(64'h0, 64'h0, 17, 3));
		send_block(make_block({64{1'b1}}, {64{1'b1}}, 128, 128));
	endtask

	task automatic test_dxt3_alpha();
		wait_drain();
		write_reg(CFG_FORMAT, 11'(MODE_DXT3));
		send_block(make_block({$urandom, $urandom}, 64'hFEDCBA9876543210, 1, 2));
		send_block(make_block({32'hE4E4E4E4, 16'h1234, 16'hABCD}, 64'h0, 7, 9));
		send_block(make_block({32'hE4E4E4E4, 16'hABCD, 16'h1234}, {64{1'b1}}, 200, 100));
	endtask

	task automatic test_dxt5_alpha();
		logic [63:0] ab;
		int          k;
		wait_drain();
		write_reg(CFG_FORMAT, 11'(MODE_DXT5));
		ab = '0;
		for (k = 0; k < 16; k++)
			ab[16 + 3 * k +: 3] = 3'(k);
		// Eight-level alpha, then six-level, then equal endpoints.
		ab[15:0] = 16'h10F0;
		send_block(make_block({$urandom, $urandom}, ab, 3, 4));
		ab[15:0] = 16'hF010;
		send_block(make_block({$urandom, $urandom}, ab, 5, 6));
		ab[15:0] = 16'h7777;
		send_block(make_block({$urandom, $urandom}, ab, 8, 9));
		send_block(make_block({$urandom, $urandom}, {{48{1'b1}}, 16'h00FF}, 10, 11));
	endtask

	task automatic test_unused_mode();
		wait_drain();
		write_reg(CFG_FORMAT, 11'(MODE_UNUSED));
		send_block(make_block({32'hE4E4E4E4, 16'h0000, 16'h0000}, {$urandom, $urandom},
			2, 2));
	endtask

	task automatic test_clipping();
		wait_drain();
		write_reg(CFG_FORMAT, 11'(MODE_DXT1));
		write_reg(CFG_WIDTH, 11'd6);
		write_reg(CFG_HEIGHT, 11'd5);
		send_block(make_block({$urandom, $urandom}, 64'h0, 1, 1));
		send_block(make_block({$urandom, $urandom}, 64'h0, 2, 0));
		send_block(make_block({$urandom, $urandom}, 64'h0, 0, 0));
		wait_drain();
		write_reg(CFG_WIDTH, 11'd0);
		send_block(make_block({$urandom, $urandom}, 64'h0, 0, 0));
		wait_drain();
		write_reg(CFG_WIDTH, 11'd2047);
		write_reg(CFG_HEIGHT, 11'd2047);
		send_block(make_block({$urandom, $urandom}, 64'h0, 255, 255));
		wait_drain();
		write_reg(CFG_WIDTH, 11'd1);
		write_reg(CFG_HEIGHT, 11'd1);
		send_block(make_block({$urandom, $urandom}, 64'h0, 0, 0));
	endtask

	task automatic test_random_traffic();
		logic [1:0]            modes[8];
		logic [CFG_DATA_W-1:0] widths[8];
		logic [CFG_DATA_W-1:0] heights[8];
		int                    p, i, col_hi, row_hi;
		modes   = '{MODE_DXT1, MODE_DXT3, MODE_DXT5, MODE_DXT5,
			MODE_DXT1, MODE_DXT3, MODE_UNUSED, MODE_DXT1};
		widths  = '{11'd1024, 11'd1024, 11'd1024, 11'd37, 11'd2047, 11'd1, 11'd130, 11'd1};
		heights = '{11'd1024, 11'd1024, 11'd1024, 11'd22, 11'd9, 11'd1024, 11'd1, 11'd1};
		for (p = 0; p < 8; p++) begin
			wait_drain();
			if (p == 7) begin
				modes[p]   = 2'($urandom_range(2));
				widths[p]  = 11'($urandom_range(1024, 1));
				heights[p] = 11'($urandom_range(1024, 1));
			end
			write_reg(CFG_FORMAT, 11'(modes[p]));
			write_reg(CFG_WIDTH, widths[p]);
			write_reg(CFG_HEIGHT, heights[p]);
			// Keep most blocks at least partly inside the image.
			col_hi = ((widths[p] < MAX_DIM ? int'(widths[p]) : MAX_DIM) + 3) / 4;
			row_hi = ((heights[p] < MAX_DIM ? int'(heights[p]) : MAX_DIM) + 3) / 4;
			col_hi = (col_hi > 255) ? 255 : col_hi;
			row_hi = (row_hi > 255) ? 255 : row_hi;
			steady = (p == 1);
			for (i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (i == ITEMS_PER_PHASE / 2)
					wait_drain();
				send_block(random_block(col_hi, row_hi));
			end
			steady = 1'b0;
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_dxt1_palettes();
		test_dxt3_alpha();
		test_dxt5_alpha();
		test_unused_mode();
		test_clipping();
		test_random_traffic();
		wait_drain();
		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
